FILE: src/updur_pkg.sv
// ----------------------------------------------------------------------------
// updur_pkg
// Shared widths, character codes and unit scales for the uptime parser.
// ----------------------------------------------------------------------------
package updur_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned SECS_W  = 64;
  localparam int unsigned SCALE_W = 25;
  localparam int unsigned HALF_W  = SECS_W / 2;

  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [SECS_W-1:0]  secs_t;
  typedef logic [SCALE_W-1:0] scale_t;

  localparam char_t CH_0     = 8'h30;
  localparam char_t CH_9     = 8'h39;
  localparam char_t CH_YEAR  = 8'h79;
  localparam char_t CH_WEEK  = 8'h77;
  localparam char_t CH_DAY   = 8'h64;
  localparam char_t CH_COLON = 8'h3a;

  localparam scale_t SCALE_YEAR = 25'(365 * 86400);
  localparam scale_t SCALE_WEEK = 25'(7 * 86400);
  localparam scale_t SCALE_DAY  = 25'(86400);
  localparam scale_t SCALE_HOUR = 25'(3600);
  localparam scale_t SCALE_MIN  = 25'(60);
  localparam scale_t SCALE_SEC  = 25'(1);
  localparam scale_t SCALE_NONE = 25'(0);

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

endpackage

FILE: src/uptime_duration_parser.sv
// ----------------------------------------------------------------------------
// uptime_duration_parser
// Parses an uptime text such as 6w6d18:33:07, one character per transfer,
// into a 64-bit count of seconds reported on the end-of-text item.
// ----------------------------------------------------------------------------
// The end item's result passes the input register, the segment operand
//   register and the multiply stage, then is accumulated into the output register.
// Throughput: one item per cycle; the whole pipe holds while a result waits.
// Segment products use two 32x25 partial products, registered once.
// Reset: synchronous, active low; clears parse state, total and valids.
// ----------------------------------------------------------------------------
module uptime_duration_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_kind,
  input  updur_pkg::char_t     in_char_code,
  output logic                 out_valid,
  input  logic                 out_stall,
  output updur_pkg::secs_t     out_seconds
);
  import updur_pkg::*;

  typedef enum logic [1:0] {
    PH_START   = 2'd0,
    PH_DIGITS  = 2'd1,
    PH_STOPPED = 2'd2
  } phase_t;

  logic en;

  // input register
  logic  a_valid_r;
  logic  a_kind_r;
  char_t a_char_r;

  // parse state
  phase_t phase_r, phase_nxt;
  secs_t  number_acc_r, number_acc_nxt;
  logic   acc_overflow_r, acc_overflow_nxt;
  logic   hour_seen_r, hour_seen_nxt;

  // segment operand stage
  logic   b_valid_r;
  logic   b_end_r, b_end_nxt;
  secs_t  b_acc_r;
  scale_t b_scale_r, b_scale_nxt;

  // partial product stage
  logic                      c_valid_r;
  logic                      c_end_r;
  logic [HALF_W+SCALE_W-1:0] c_lo_r;
  logic [HALF_W-1:0]         c_hi_r;

  // total and result
  secs_t running_total_r;
  secs_t sum;
  logic  out_valid_r;
  secs_t out_seconds_r;

  logic               is_digit;
  logic [CHAR_W-1:0]  diff;
  logic [SECS_W+3:0]  acc_ext;
  logic [SECS_W+3:0]  acc_wide;
  logic               wide_ovf;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  assign is_digit = (a_char_r >= CH_0) && (a_char_r <= CH_9);
  assign diff     = a_char_r - CH_0;
  assign acc_ext  = (phase_r == PH_START) ? '0 : {4'd0, number_acc_r};
  assign acc_wide = (acc_ext << 3) + (acc_ext << 1) + {{SECS_W{1'b0}}, diff[3:0]};
  assign wide_ovf = |acc_wide[SECS_W+3:SECS_W];

  always_comb begin
    phase_nxt        = phase_r;
    number_acc_nxt   = number_acc_r;
    acc_overflow_nxt = acc_overflow_r;
    hour_seen_nxt    = hour_seen_r;
    b_end_nxt        = 1'b0;
    b_scale_nxt      = SCALE_NONE;
    if (a_valid_r) begin
      if (a_kind_r == KIND_END) begin
        b_end_nxt        = 1'b1;
        b_scale_nxt      = (phase_r == PH_DIGITS && !acc_overflow_r) ? SCALE_SEC : SCALE_NONE;
        phase_nxt        = PH_START;
        number_acc_nxt   = '0;
        acc_overflow_nxt = 1'b0;
        hour_seen_nxt    = 1'b0;
      end else begin
        unique case (phase_r)
          PH_START: begin
            if (is_digit) begin
              number_acc_nxt   = acc_wide[SECS_W-1:0];
              acc_overflow_nxt = wide_ovf;
              phase_nxt        = PH_DIGITS;
            end else begin
              phase_nxt = PH_STOPPED;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              if (!acc_overflow_r) begin
                number_acc_nxt   = acc_wide[SECS_W-1:0];
                acc_overflow_nxt = wide_ovf;
              end
            end else if (acc_overflow_r) begin
              phase_nxt = PH_STOPPED;
            end else begin
              unique case (a_char_r)
                CH_YEAR:  b_scale_nxt = SCALE_YEAR;
                CH_WEEK:  b_scale_nxt = SCALE_WEEK;
                CH_DAY:   b_scale_nxt = SCALE_DAY;
                CH_COLON: begin
                  b_scale_nxt   = hour_seen_r ? SCALE_MIN : SCALE_HOUR;
                  hour_seen_nxt = 1'b1;
                end
                default:  b_scale_nxt = SCALE_SEC;
              endcase
              number_acc_nxt = '0;
              phase_nxt      = PH_START;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign sum = running_total_r + {{(SECS_W-HALF_W-SCALE_W){1'b0}}, c_lo_r}
             + {c_hi_r, {HALF_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r       <= 1'b0;
      b_valid_r       <= 1'b0;
      c_valid_r       <= 1'b0;
      out_valid_r     <= 1'b0;
      phase_r         <= PH_START;
      number_acc_r    <= '0;
      acc_overflow_r  <= 1'b0;
      hour_seen_r     <= 1'b0;
      running_total_r <= '0;
    end else if (en) begin
      a_valid_r      <= in_valid;
      phase_r        <= phase_nxt;
      number_acc_r   <= number_acc_nxt;
      acc_overflow_r <= acc_overflow_nxt;
      hour_seen_r    <= hour_seen_nxt;
      b_valid_r      <= a_valid_r;
      c_valid_r      <= b_valid_r;
      out_valid_r    <= c_valid_r && c_end_r;
      if (c_valid_r) begin
        running_total_r <= c_end_r ? '0 : sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_kind_r      <= in_kind;
      a_char_r      <= in_char_code;
      b_end_r       <= b_end_nxt;
      b_acc_r       <= number_acc_r;
      b_scale_r     <= b_scale_nxt;
      c_end_r       <= b_end_r;
      c_lo_r        <= b_acc_r[HALF_W-1:0] * b_scale_r;
      c_hi_r        <= HALF_W'(b_acc_r[SECS_W-1:HALF_W] * b_scale_r);
      out_seconds_r <= sum;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_seconds = out_seconds_r;

  a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    (en && a_valid_r && a_kind_r == KIND_END) |=>
      (phase_r == PH_START && number_acc_r == '0 && !hour_seen_r && !acc_overflow_r))
    else $error("parse state not cleared after end item");

  a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(c_valid_r && c_end_r))
    else $error("result raised without an end item in flight");

  a_total_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (en && c_valid_r && c_end_r) |=> (running_total_r == '0))
    else $error("running total not cleared after result");

endmodule
